// ----- src/mm2_pkg.sv -----
package mm2_pkg;

  // Mixing constants
  localparam logic [31:0] MIX_MUL      = 32'h5bd1e995;
  localparam int          MIX_SHIFT    = 24;
  localparam int          AVAL_SHIFT_A = 13;
  localparam int          AVAL_SHIFT_B = 15;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Full-word count, and the widths of the tail masks for one to three bytes
  localparam logic [2:0]  BYTES_FULL = 3'd4;
  localparam logic [2:0]  BYTES_ONE  = 3'd1;
  localparam logic [2:0]  BYTES_TWO  = 3'd2;
  localparam logic [31:0] MASK_ONE   = 32'h0000_00ff;
  localparam logic [31:0] MASK_TWO   = 32'h0000_ffff;
  localparam logic [31:0] MASK_THREE = 32'h00ff_ffff;

  // What the back end does with a word
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,  // last item with no bytes: avalanche only
    OP_MIX  = 2'd1,  // full word mix
    OP_TAIL = 2'd2   // one to three tail bytes
  } op_t;

  // One classified item, as queued between front and back
  typedef struct packed {
    logic [31:0] word;       // already masked for a tail
    logic [31:0] init_hash;  // seed xor length
    op_t         op;
    logic        first;
    logic        last;
  } entry_t;

endpackage

// ----- src/mm2_front.sv -----
module mm2_front (
  input  logic            clk,
  input  logic            rst_n,
  // configuration
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_hash_seed,
  // input items
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     in_data_word,
  input  logic [2:0]      in_bytes_valid,
  input  logic            in_first_item,
  input  logic            in_last_item,
  input  logic [31:0]     in_message_length,
  // to queue
  input  logic            q_full,
  output logic            q_push,
  output mm2_pkg::entry_t q_entry
);

  logic [31:0] seed_r;
  logic [31:0] mask;

  // Seed register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid) begin
      seed_r <= cfg_hash_seed;
    end
  end

  // Tail byte mask
  always_comb begin
    case (in_bytes_valid)
      mm2_pkg::BYTES_ONE: mask = mm2_pkg::MASK_ONE;
      mm2_pkg::BYTES_TWO: mask = mm2_pkg::MASK_TWO;
      default:            mask = mm2_pkg::MASK_THREE;
    endcase
  end

  // Classify the item
  always_comb begin
    q_entry.init_hash = seed_r ^ in_message_length;
    q_entry.first     = in_first_item;
    q_entry.last      = in_last_item;
    q_entry.word      = in_data_word;
    if (!in_last_item || (in_bytes_valid >= mm2_pkg::BYTES_FULL)) begin
      q_entry.op = mm2_pkg::OP_MIX;
    end else if (in_bytes_valid != 3'd0) begin
      q_entry.op   = mm2_pkg::OP_TAIL;
      q_entry.word = in_data_word & mask;
    end else begin
      q_entry.op = mm2_pkg::OP_NONE;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ----- src/mm2_queue.sv -----
module mm2_queue #(
  parameter int DEPTH = mm2_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mm2_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output mm2_pkg::entry_t pop_entry,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mm2_pkg::entry_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not shrink on pop");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count past depth");

endmodule

// ----- src/mm2_back.sv -----
module mm2_back (
  input  logic            clk,
  input  logic            rst_n,
  // from queue
  input  logic            q_empty,
  input  mm2_pkg::entry_t q_entry,
  output logic            q_pop,
  // results
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_digest
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_K1   = 6'b000010,  // k *= M
    ST_K2   = 6'b000100,  // k ^= k >> 24; k *= M
    ST_HM   = 6'b001000,  // h = h * M ^ k
    ST_TAIL = 6'b010000,  // h = (h ^ tail) * M
    ST_AV   = 6'b100000   // avalanche into output register
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_digest_r, out_digest_nxt;
  logic [31:0] mul_in;
  logic [31:0] product;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  // Shared constant multiplier, operand picked by step
  always_comb begin
    case (state_r)
      ST_K2:   mul_in = k_r ^ (k_r >> mm2_pkg::MIX_SHIFT);
      ST_HM:   mul_in = h_r;
      ST_TAIL: mul_in = h_r ^ k_r;
      ST_AV:   mul_in = h_r ^ (h_r >> mm2_pkg::AVAL_SHIFT_A);
      default: mul_in = k_r;
    endcase
  end

  assign product = mul_in * mm2_pkg::MIX_MUL;

  // Step sequencer
  always_comb begin
    state_nxt      = state_r;
    h_nxt          = h_r;
    k_nxt          = k_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_digest_nxt = out_digest_r;
    q_pop          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          h_nxt    = q_entry.first ? q_entry.init_hash : h_r;
          k_nxt    = q_entry.word;
          last_nxt = q_entry.last;
          case (q_entry.op)
            mm2_pkg::OP_MIX:  state_nxt = ST_K1;
            mm2_pkg::OP_TAIL: state_nxt = ST_TAIL;
            default:          state_nxt = q_entry.last ? ST_AV : ST_IDLE;
          endcase
        end
      end
      ST_K1: begin
        k_nxt     = product;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        k_nxt     = product;
        state_nxt = ST_HM;
      end
      ST_HM: begin
        h_nxt     = product ^ k_r;
        state_nxt = last_r ? ST_AV : ST_IDLE;
      end
      ST_TAIL: begin
        h_nxt     = product;
        state_nxt = last_r ? ST_AV : ST_IDLE;
      end
      ST_AV: begin
        // wait for the output register to free up
        if (out_free) begin
          out_digest_nxt = product ^ (product >> mm2_pkg::AVAL_SHIFT_B);
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    last_r       <= last_nxt;
    out_digest_r <= out_digest_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_digest = out_digest_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && state_r == ST_IDLE))
    else $error("pop from empty queue or while busy");

  a_result_from_av: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_AV))
    else $error("result raised outside avalanche step");

  a_av_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AV && !out_free) |=> (state_r == ST_AV && $stable(h_r)))
    else $error("avalanche step left while output blocked");

  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && q_empty) |=> (state_r == ST_IDLE && $stable(h_r)))
    else $error("back end moved without a queued item");

endmodule

// ----- src/murmur2_32_hash.sv -----
// Channel | Ports                                           | Direction
// --------+-------------------------------------------------+----------
// input   | in_valid/in_ready, in_data_word, in_bytes_valid, | in
//         | in_first_item, in_last_item, in_message_length  |
// result  | out_valid/out_ready, out_digest                  | out
// config  | cfg_valid/cfg_ready, cfg_hash_seed               | in
//
// Steps: the back end takes an item from the queue in its idle step, then
// runs K1, K2 and HM on a full word or TAIL on a tail, plus the avalanche
// step AV on a last item; one shared 32x32 constant multiplier serves every
// step but the idle one.
// The front end accepts up to QUEUE_DEPTH items ahead of the back end.
// Reset (synchronous, rst_n low) clears the seed, running hash and queue.
// A digest waiting in the output register stalls only the avalanche step.
module murmur2_32_hash #(
  parameter int QUEUE_DEPTH = mm2_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_hash_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_bytes_valid,
  input  logic        in_first_item,
  input  logic        in_last_item,
  input  logic [31:0] in_message_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest
);

  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  mm2_pkg::entry_t push_entry;
  mm2_pkg::entry_t pop_entry;

  // Seed register and item classification
  mm2_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_hash_seed     (cfg_hash_seed),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_word      (in_data_word),
    .in_bytes_valid    (in_bytes_valid),
    .in_first_item     (in_first_item),
    .in_last_item      (in_last_item),
    .in_message_length (in_message_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (push_entry)
  );

  // Classified items waiting for the back end
  mm2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // Mixing sequencer and output register
  mm2_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_digest (out_digest)
  );

endmodule
